/* design/bb3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 box blur
// Pixel and counter widths, register indexes and the reciprocal constant
// used for the divide by nine.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int IDX_W     = $clog2(MAX_WIDTH);

    localparam int PIX_W     = 16;
    localparam int FWIDTH_W  = 11;
    localparam int FHEIGHT_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // Column compare width: wide enough for both the register and the depth.
    localparam int CNT_W = (IDX_W + 1 > FWIDTH_W) ? IDX_W + 1 : FWIDTH_W;

    // Nine pixels plus the rounding offset fit in four extra bits.
    localparam int SUM_W = PIX_W + 4;

    // floor(x / 9) == (x * DIV9_MUL) >> DIV9_SHIFT for every x below 2**SUM_W.
    localparam int DIV9_SHIFT = SUM_W + 3;
    localparam int DIV9_MUL_I = ((1 << DIV9_SHIFT) + 8) / 9;
    localparam int PROD_W     = 2 * SUM_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [SUM_W-1:0] t_sum;

endpackage

/* design/bb3_pix_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pix_if: input pixel channel
// One raster-order pixel per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bb3_pix_if;
    import bb3_pkg::*;

    logic valid;
    logic ready;
    t_pix pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

/* design/bb3_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_res_if: blurred result channel
// One interior mean per request, with the end-of-frame mark.
// ----------------------------------------------------------------------------
interface bb3_res_if;
    import bb3_pkg::*;

    logic valid;
    logic ready;
    t_pix blurred_pixel;
    logic frame_done;

    modport source (output valid, output blurred_pixel, output frame_done, input ready);
    modport sink   (input valid, input blurred_pixel, input frame_done, output ready);
endinterface

/* design/bb3_line_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_line_buffer: two row stores of the blur window
// Upper holds row r-2 and lower row r-1. Reads are registered; a write moves
// the read lower value up and stores the new pixel in the lower row.
// ----------------------------------------------------------------------------
module bb3_line_buffer
    import bb3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_pix             i_wr_pix,
    output t_pix             o_up,
    output t_pix             o_mid
);

    t_pix r_upper [MAX_WIDTH];
    t_pix r_lower [MAX_WIDTH];
    t_pix r_up;
    t_pix r_mid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_upper[i_wr_addr] <= r_mid;
            r_lower[i_wr_addr] <= i_wr_pix;
        end
        if (i_rd_en) begin
            r_up  <= r_upper[i_rd_addr];
            r_mid <= r_lower[i_rd_addr];
        end
    end

    assign o_up  = r_up;
    assign o_mid = r_mid;

endmodule

/* design/bb3_window_sum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_window_sum: 3x3 window registers and adder tree
// Holds the two previous columns of the band and sums them with the new
// column, adding the rounding offset for the divide by nine.
// ----------------------------------------------------------------------------
module bb3_window_sum
    import bb3_pkg::*;
(
    input  logic i_clk,
    input  logic i_shift,
    input  t_pix i_up,
    input  t_pix i_mid,
    input  t_pix i_pix,
    output t_sum o_sum
);

    // Entries 0..2 are column c-2, entries 3..5 column c-1, top to bottom.
    t_pix r_win [6];
    t_sum s_col_old;
    t_sum s_col_prev;
    t_sum s_col_new;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= i_up;
            r_win[4] <= i_mid;
            r_win[5] <= i_pix;
        end
    end

    always_comb begin
        s_col_old  = t_sum'(r_win[0]) + t_sum'(r_win[1]) + t_sum'(r_win[2]);
        s_col_prev = t_sum'(r_win[3]) + t_sum'(r_win[4]) + t_sum'(r_win[5]);
        s_col_new  = t_sum'(i_up) + t_sum'(i_mid) + t_sum'(i_pix);
        o_sum      = s_col_old + s_col_prev + s_col_new + t_sum'(4);
    end

endmodule

/* design/bb3_div9.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_div9: divide by nine
// Exact floor division of the rounded window sum by a reciprocal multiply.
// ----------------------------------------------------------------------------
module bb3_div9
    import bb3_pkg::*;
(
    input  t_sum i_sum,
    output t_pix o_quot
);

    localparam logic [SUM_W-1:0] DIV9_MUL = SUM_W'(DIV9_MUL_I);

    logic [PROD_W-1:0] s_prod;

    always_comb begin
        s_prod = PROD_W'(i_sum) * PROD_W'(DIV9_MUL);
        o_quot = s_prod[DIV9_SHIFT +: PIX_W];
    end

endmodule

/* design/box_blur_3x3_stencil.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_stencil: 3x3 box mean over a raster pixel stream
// Two line stores and a six-register window give the 3x3 neighborhood of
// each interior pixel; the result is the mean rounded to nearest.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake      Payload
//  i_pix     in         valid/ready    pixel_in (16b, unsigned Q8.8)
//  o_res     out        valid/ready    blurred_pixel (16b), frame_done (1b)
//  i_cfg_*   in         write enable   index (0 width, 1 height), 16b data
//
// One pixel request is accepted per clock while o_res is not stalled. A result
// reaches the output register after the request that completes its window: the
// line store read, the window adder tree and the divide-by-nine multiply
// each take one stage. The edge ring of the frame gives no result.
// Reset clears the counters, the pipeline valid bits and the registers to
// 1024 x 1024; line store contents are undefined until rows are written.
// A stall on o_res fills the two internal stages before i_pix.ready drops.
// ----------------------------------------------------------------------------
module box_blur_3x3_stencil
    import bb3_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    bb3_pix_if.sink              i_pix,
    bb3_res_if.source            o_res
);

    // Configuration registers.
    logic [FWIDTH_W-1:0]  r_frame_width;
    logic [FHEIGHT_W-1:0] r_frame_height;

    // Position of the next pixel in the frame.
    logic [IDX_W-1:0]     r_col;
    logic [FHEIGHT_W-1:0] r_row;

    // Stage 1: line store read data is in flight, pixel and flags held here.
    logic             r_s1_valid;
    logic             r_s1_res;
    logic             r_s1_done;
    logic [IDX_W-1:0] r_s1_idx;
    t_pix             r_s1_pix;

    // Stage 2: rounded window sum.
    logic r_s2_valid;
    logic r_s2_done;
    t_sum r_s2_sum;

    // Output register.
    logic r_o_valid;
    logic r_o_done;
    t_pix r_o_pix;

    logic [CNT_W-1:0]     s_width_eff;
    logic [CNT_W-1:0]     s_width_m1;
    logic [FHEIGHT_W-1:0] s_height_m1;
    logic                 s_last_col;
    logic                 s_last_row;
    logic                 s_out_free;
    logic                 s_s2_free;
    logic                 s_s1_fire;
    logic                 s_s1_free;
    logic                 s_accept;
    t_pix                 s_up;
    t_pix                 s_mid;
    t_sum                 s_sum;
    t_pix                 s_quot;

    // Effective frame size: width clamped to [3, MAX_WIDTH], height to >= 3.
    always_comb begin
        if (r_frame_width < FWIDTH_W'(3)) begin
            s_width_eff = CNT_W'(3);
        end else if (CNT_W'(r_frame_width) > CNT_W'(MAX_WIDTH)) begin
            s_width_eff = CNT_W'(MAX_WIDTH);
        end else begin
            s_width_eff = CNT_W'(r_frame_width);
        end
        s_width_m1 = s_width_eff - CNT_W'(1);
        if (r_frame_height < FHEIGHT_W'(3)) begin
            s_height_m1 = FHEIGHT_W'(2);
        end else begin
            s_height_m1 = r_frame_height - FHEIGHT_W'(1);
        end
        // A counter beyond the limit after a mid-frame change also ends the line.
        s_last_col = CNT_W'(r_col) >= s_width_m1;
        s_last_row = r_row >= s_height_m1;
    end

    // Pipeline flow: each stage moves when the one after it can take its item.
    // Stage 1 always moves on (it updates the stores and the window) even
    // when its pixel lies on the border and produces no result.
    always_comb begin
        s_out_free  = !r_o_valid || o_res.ready;
        s_s2_free   = !r_s2_valid || s_out_free;
        s_s1_fire   = r_s1_valid && s_s2_free;
        s_s1_free   = !r_s1_valid || s_s2_free;
        s_accept    = i_pix.valid && s_s1_free;
        i_pix.ready = s_s1_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FWIDTH_W'(MAX_WIDTH);
            r_frame_height <= FHEIGHT_W'(1024);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[FWIDTH_W-1:0];
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[FHEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Raster counters advance on every accepted pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (s_accept) begin
            if (s_last_col) begin
                r_col <= '0;
                r_row <= s_last_row ? '0 : r_row + FHEIGHT_W'(1);
            end else begin
                r_col <= r_col + IDX_W'(1);
            end
        end
    end

    // Stage 1 register. The line stores are read at the same edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_s1_free) begin
            r_s1_valid <= s_accept;
        end
        if (s_accept) begin
            r_s1_res  <= (r_row >= FHEIGHT_W'(2)) && (r_col >= IDX_W'(2));
            r_s1_done <= s_last_col && s_last_row;
            r_s1_idx  <= r_col;
            r_s1_pix  <= i_pix.pixel_in;
        end
    end

    // Consecutive pixels never share a column, so the write of stage 1 and
    // the read of the new pixel never meet at one address.
    bb3_line_buffer u_line_buffer (
        .i_clk     (i_clk),
        .i_rd_en   (s_accept),
        .i_rd_addr (r_col),
        .i_wr_en   (s_s1_fire),
        .i_wr_addr (r_s1_idx),
        .i_wr_pix  (r_s1_pix),
        .o_up      (s_up),
        .o_mid     (s_mid)
    );

    bb3_window_sum u_window_sum (
        .i_clk   (i_clk),
        .i_shift (s_s1_fire),
        .i_up    (s_up),
        .i_mid   (s_mid),
        .i_pix   (r_s1_pix),
        .o_sum   (s_sum)
    );

    // Stage 2 register: only interior pixels carry on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s_s2_free) begin
            r_s2_valid <= s_s1_fire && r_s1_res;
        end
        if (s_s2_free) begin
            r_s2_sum  <= s_sum;
            r_s2_done <= r_s1_done;
        end
    end

    bb3_div9 u_div9 (
        .i_sum  (r_s2_sum),
        .o_quot (s_quot)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s_out_free) begin
            r_o_valid <= r_s2_valid;
        end
        if (s_out_free) begin
            r_o_pix  <= s_quot;
            r_o_done <= r_s2_done;
        end
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.blurred_pixel = r_o_pix;
    assign o_res.frame_done    = r_o_done;

endmodule
